// ===== sv/gbr_pkg.sv =====
// Package for the GB18030 four-byte range mapper.
// Holds the table entry type, the byte builder handshake types, the op codes
// and the linearizing function. Depends on nothing.
`default_nettype none

package gbr_pkg;

  localparam int RANGE_DEPTH = 256;
  localparam int IDX_W       = 8;
  localparam int CNT_W       = 9;
  localparam int LIN_W       = 22;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_DECODE = 2'd1;
  localparam logic [1:0] OP_ENCODE = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // Linear form of the sequence 81 30 81 30.
  localparam logic [31:0] LIN_BASE = 32'd1687218;

  localparam logic [7:0] LEAD_BASE  = 8'h81;
  localparam logic [7:0] DIGIT_BASE = 8'h30;
  localparam logic [7:0] DIV_TEN    = 8'd10;
  localparam logic [7:0] DIV_TRAIL  = 8'd126;

  typedef struct packed {
    logic [31:0]      code_first;
    logic [31:0]      code_last;
    logic [LIN_W-1:0] lin_first;
    logic [LIN_W-1:0] lin_last;
  } entry_t;

  typedef struct packed {
    logic        start;
    logic [31:0] value;
  } bb_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] bytes;
  } bb_rsp_t;

  // ((b0*10+b1)*126+b2)*10+b3; every byte pattern stays below 2^22.
  function automatic logic [LIN_W-1:0] lin_of(input logic [31:0] w);
    logic [11:0] t1;
    logic [18:0] t2;
    logic [21:0] t3;
    t1 = {4'd0, w[31:24]} * 12'd10 + {4'd0, w[23:16]};
    t2 = {7'd0, t1} * 19'd126 + {11'd0, w[15:8]};
    t3 = {3'd0, t2} * 22'd10 + {14'd0, w[7:0]};
    return t3;
  endfunction

endpackage

`default_nettype wire

// ===== sv/gbr_range_ram.sv =====
// Range table storage: one synchronous RAM of packed range entries.
// One write port and one read port with registered read data. Uses gbr_pkg.
`default_nettype none

module gbr_range_ram (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [gbr_pkg::IDX_W-1:0] waddr,
  input  wire gbr_pkg::entry_t          wdata,
  input  wire logic [gbr_pkg::IDX_W-1:0] raddr,
  output gbr_pkg::entry_t               rdata
);
  import gbr_pkg::*;

  entry_t mem [RANGE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/gbr_byte_builder.sv =====
// Rebuilds four GB18030 bytes from a linear offset above 81 30 81 30.
// Three reciprocal multiplications divide by 10, 126 and 10, one per cycle, and
// each remainder is taken in the phase after its quotient. Uses gbr_pkg.
`default_nettype none

module gbr_byte_builder (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire gbr_pkg::bb_req_t req,
  output gbr_pkg::bb_rsp_t      rsp
);
  import gbr_pkg::*;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_LOW   = 3'd1;
  localparam logic [2:0] PH_TRAIL = 3'd2;
  localparam logic [2:0] PH_HIGH  = 3'd3;
  localparam logic [2:0] PH_LAST  = 3'd4;
  localparam logic [2:0] PH_DONE  = 3'd5;

  // floor(x / 10) is (x * RECIP_TEN) >> 35 for any 32-bit x, and
  // floor(x / 126) is (x * RECIP_TRAIL) >> 36 for any x below 2^29.
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam logic [31:0] RECIP_TRAIL = 32'd545392673;

  logic [2:0]  phase;
  logic [31:0] w;
  logic [31:0] prev;
  logic [3:0]  r3;
  logic [6:0]  r2;
  logic [3:0]  r1;

  logic [31:0] recip;
  logic [63:0] prod;
  logic [31:0] quot;
  logic [31:0] rem_ten;
  logic [31:0] rem_trail;

  always_comb begin
    case (phase)
      PH_TRAIL: recip = RECIP_TRAIL;
      default:  recip = RECIP_TEN;
    endcase
    prod = {32'd0, w} * {32'd0, recip};
    case (phase)
      PH_TRAIL: quot = {4'd0, prod[63:36]};
      default:  quot = {3'd0, prod[63:35]};
    endcase
    // prev holds the dividend whose quotient now sits in w.
    rem_ten   = prev - w * {24'd0, DIV_TEN};
    rem_trail = prev - w * {24'd0, DIV_TRAIL};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (req.start) begin
      phase <= PH_LOW;
    end else begin
      case (phase)
        PH_LOW:   phase <= PH_TRAIL;
        PH_TRAIL: phase <= PH_HIGH;
        PH_HIGH:  phase <= PH_LAST;
        PH_LAST:  phase <= PH_DONE;
        default:  phase <= phase;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      w <= req.value;
    end else begin
      case (phase)
        PH_LOW: begin
          prev <= w;
          w    <= quot;
        end
        PH_TRAIL: begin
          r3   <= rem_ten[3:0];
          prev <= w;
          w    <= quot;
        end
        PH_HIGH: begin
          r2   <= rem_trail[6:0];
          prev <= w;
          w    <= quot;
        end
        PH_LAST: begin
          r1 <= rem_ten[3:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign rsp.done  = phase == PH_DONE;
  assign rsp.bytes = {LEAD_BASE + w[7:0],
                      DIGIT_BASE + {4'd0, r1},
                      LEAD_BASE + {1'b0, r2},
                      DIGIT_BASE + {4'd0, r3}};

endmodule

`default_nettype wire

// ===== sv/gb18030_four_byte_range_mapper.sv =====
// GB18030 four-byte range mapper. The table RAM is read one entry per cycle.
// A lookup passes S_LIN, S_SCAN, S_CALC and for an encode hit S_DIV; its result
// is registered on the first match or once all searched entries miss. A load is
// written in S_LIN. One request is in work at a time; the next is taken the
// cycle after a result is registered, while that result waits for the receiver.
// Synchronous reset clears control and range_count; table entries are undefined.
`default_nettype none

module gb18030_four_byte_range_mapper (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_wen,
  input  wire logic [gbr_pkg::CNT_W-1:0] cfg_wdata,
  input  wire logic                     item_valid,
  output logic                          item_stall,
  input  wire logic [1:0]               op,
  input  wire logic [gbr_pkg::IDX_W-1:0] entry_index,
  input  wire logic [31:0]              code_in,
  input  wire logic [31:0]              load_code_first,
  input  wire logic [31:0]              load_code_last,
  input  wire logic [31:0]              load_bytes_first,
  input  wire logic [31:0]              load_bytes_last,
  output logic                          result_valid,
  input  wire logic                     result_stall,
  output logic                          found,
  output logic [31:0]                   code_out
);
  import gbr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LIN  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_CALC = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(RANGE_DEPTH);

  logic [2:0]       state;
  logic [CNT_W-1:0] range_count;

  logic [1:0]       op_r;
  logic [IDX_W-1:0] idx_r;
  logic [31:0]      code_r;
  logic [31:0]      ld_code_first;
  logic [31:0]      ld_code_last;
  logic [31:0]      ld_bytes_first;
  logic [31:0]      ld_bytes_last;
  logic [LIN_W-1:0] key_lin;

  logic [CNT_W-1:0] scan_cnt;
  logic             rd_valid;
  logic             hit_found;
  logic [31:0]      hit_code_first;
  logic [LIN_W-1:0] hit_lin_first;

  logic             ram_we;
  entry_t           ram_wdata;
  entry_t           rdata;
  logic [CNT_W-1:0] limit;
  logic             match;
  logic             hit;
  logic             out_free;
  logic [31:0]      dec_code;
  bb_req_t          bb_req;
  bb_rsp_t          bb_rsp;

  assign item_stall = state != S_IDLE;
  assign limit      = (range_count > DEPTH_CNT) ? DEPTH_CNT : range_count;
  assign out_free   = !result_valid || !result_stall;

  always_comb begin
    if (op_r == OP_DECODE) begin
      match = (rdata.lin_first <= key_lin) && (key_lin <= rdata.lin_last);
    end else begin
      match = (rdata.code_first <= code_r) && (code_r <= rdata.code_last);
    end
    hit = rd_valid && match;
  end

  assign ram_we    = (state == S_LIN) && (op_r == OP_LOAD);
  assign ram_wdata = '{code_first: ld_code_first,
                       code_last:  ld_code_last,
                       lin_first:  lin_of(ld_bytes_first),
                       lin_last:   lin_of(ld_bytes_last)};

  assign dec_code = hit_code_first
                  + ({{(32-LIN_W){1'b0}}, key_lin} - {{(32-LIN_W){1'b0}}, hit_lin_first});

  assign bb_req.start = (state == S_CALC) && hit_found && (op_r == OP_ENCODE);
  assign bb_req.value = {{(32-LIN_W){1'b0}}, hit_lin_first} + (code_r - hit_code_first)
                      - LIN_BASE;

  gbr_range_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (ram_wdata),
    .raddr (scan_cnt[IDX_W-1:0]),
    .rdata (rdata)
  );

  gbr_byte_builder u_bytes (
    .clk (clk),
    .rst (rst),
    .req (bb_req),
    .rsp (bb_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      range_count <= '0;
    end else if (cfg_wen) begin
      range_count <= cfg_wdata;
    end
  end

  // Request capture, key linearization in S_LIN and hit entry capture in S_SCAN.
  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      op_r           <= op;
      idx_r          <= entry_index;
      code_r         <= code_in;
      ld_code_first  <= load_code_first;
      ld_code_last   <= load_code_last;
      ld_bytes_first <= load_bytes_first;
      ld_bytes_last  <= load_bytes_last;
    end
    if (state == S_LIN) begin
      key_lin <= lin_of(code_r);
    end
    if ((state == S_SCAN) && hit) begin
      hit_code_first <= rdata.code_first;
      hit_lin_first  <= rdata.lin_first;
    end
  end

  // Sequencer. The scan issues one read per cycle and checks the entry read
  // in the cycle before, so a hit may leave one extra read unused.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scan_cnt  <= '0;
      rd_valid  <= 1'b0;
      hit_found <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid && !item_stall && (op != OP_NONE)) begin
            state <= S_LIN;
          end
        end
        S_LIN: begin
          scan_cnt <= '0;
          rd_valid <= 1'b0;
          state    <= (op_r == OP_LOAD) ? S_IDLE : S_SCAN;
        end
        S_SCAN: begin
          if (hit) begin
            hit_found <= 1'b1;
            state     <= S_CALC;
          end else if (scan_cnt == limit) begin
            hit_found <= 1'b0;
            state     <= S_CALC;
          end else begin
            scan_cnt <= scan_cnt + CNT_W'(1);
            rd_valid <= 1'b1;
          end
        end
        S_CALC: begin
          if (hit_found && (op_r == OP_ENCODE)) begin
            state <= S_DIV;
          end else if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          if (bb_rsp.done && out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == S_CALC) && !(hit_found && (op_r == OP_ENCODE)) && out_free) begin
      result_valid <= 1'b1;
    end else if ((state == S_DIV) && bb_rsp.done && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_CALC) && !(hit_found && (op_r == OP_ENCODE)) && out_free) begin
      found    <= hit_found;
      code_out <= hit_found ? dec_code : 32'd0;
    end else if ((state == S_DIV) && bb_rsp.done && out_free) begin
      found    <= 1'b1;
      code_out <= bb_rsp.bytes;
    end
  end

endmodule

`default_nettype wire
